// ----- src/adpcmb_pkg.sv -----
`timescale 1ns / 1ps

package adpcmb_pkg;

  localparam int unsigned PcmW  = 16;
  localparam int unsigned StepW = 15;
  localparam int unsigned CodeW = 4;

  localparam logic [StepW-1:0] StepMin = 15'd127;
  localparam logic [StepW-1:0] StepMax = 15'd24576;

  // one-hot controller states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIFF = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_UPD  = 5'b10000
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic       load;     // input transfer: capture item, apply restart
    logic       diff;     // encode: difference, sign and saturation check
    logic       div_en;   // encode: one quotient bit
    logic [1:0] div_sh;   // bit position of the quotient bit (2, 1, 0)
    logic       mul;      // delta and step products
    logic       upd;      // write predictor, step and output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic mode;      // 1: encode
    logic out_free;  // output register can take a result this cycle
  } status_t;

  // step scale factor over 64, by magnitude
  function automatic logic [7:0] step_scale(input logic [2:0] mag);
    logic [7:0] f;
    unique case (mag)
      3'd4:    f = 8'd77;
      3'd5:    f = 8'd102;
      3'd6:    f = 8'd128;
      3'd7:    f = 8'd153;
      default: f = 8'd57;
    endcase
    return f;
  endfunction

endpackage

// ----- src/adpcmb_ctrl.sv -----
`timescale 1ns / 1ps

module adpcmb_ctrl import adpcmb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e     state_q, state_d;
  logic [1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cmd_o        = '0;
    cmd_o.div_sh = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.mode ? ST_DIFF : ST_MUL;
        end
      end
      ST_DIFF: begin
        cmd_o.diff = 1'b1;
        cnt_d      = 2'd2;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_en = 1'b1;
        if (cnt_q == 2'd0) begin
          state_d = ST_MUL;
        end else begin
          cnt_d = cnt_q - 2'd1;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_UPD;
      end
      ST_UPD: begin
        // hold the finished item until the output register is free
        if (status_i.out_free) begin
          cmd_o.upd = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- src/adpcmb_dp.sv -----
`timescale 1ns / 1ps

module adpcmb_dp import adpcmb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  cmd_t             cmd_i,
  output status_t          status_o,
  input  logic             restart_i,
  input  logic [7:0]       value_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [PcmW-1:0]  pcm_o,
  output logic [CodeW-1:0] code_o,
  output logic [StepW-1:0] step_o
);

  logic             mode_q;
  logic             out_valid_q;
  logic [PcmW-1:0]  pred_q;
  logic [StepW-1:0] step_q;
  logic [7:0]       value_q;
  logic [CodeW-1:0] code_q;
  logic [17:0]      rem_q;
  logic             sat_q;
  logic [18:0]      dprod_q;
  logic [22:0]      sprod_q;
  logic [PcmW-1:0]  pcm_q;
  logic [CodeW-1:0] ocode_q;
  logic [StepW-1:0] ostep_q;

  logic [16:0]      diff;
  logic [16:0]      absd;
  logic [17:0]      cand;
  logic             qbit;
  logic [2:0]       mag;
  logic [15:0]      delta;
  logic [17:0]      sum;
  logic [PcmW-1:0]  pred_d;
  logic [16:0]      ns;
  logic [StepW-1:0] step_d;

  // sample * 256 minus predictor, 17 bits signed
  assign diff = {value_q[7], value_q, 8'h00} - {pred_q[15], pred_q};
  assign absd = diff[16] ? (~diff + 17'd1) : diff;

  // restoring divide: |diff| * 4 against step << sh
  assign cand = {3'b000, step_q} << cmd_i.div_sh;
  assign qbit = (rem_q >= cand);

  assign mag = code_q[2:0];

  // delta is non-negative, so the shift truncates toward zero
  assign delta = dprod_q[18:3];
  assign sum   = code_q[3] ? ({{2{pred_q[15]}}, pred_q} - {2'b00, delta})
                           : ({{2{pred_q[15]}}, pred_q} + {2'b00, delta});

  always_comb begin
    if (!sum[17] && (sum[16:15] != 2'b00)) begin
      pred_d = 16'h7fff;
    end else if (sum[17] && (sum[16:15] != 2'b11)) begin
      pred_d = 16'h8000;
    end else begin
      pred_d = sum[15:0];
    end
  end

  assign ns = sprod_q[22:6];

  always_comb begin
    if (ns > {2'b00, StepMax}) begin
      step_d = StepMax;
    end else if (ns < {2'b00, StepMin}) begin
      step_d = StepMin;
    end else begin
      step_d = ns[StepW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
      pred_q      <= '0;
      step_q      <= StepMin;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (cmd_i.upd) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load && restart_i) begin
        pred_q <= '0;
        step_q <= StepMin;
      end else if (cmd_i.upd) begin
        pred_q <= pred_d;
        step_q <= step_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q <= value_i;
      code_q  <= value_i[3:0];
    end
    if (cmd_i.diff) begin
      code_q  <= {diff[16], 3'b000};
      rem_q   <= {absd[15:0], 2'b00};
      // quotient of 8 or more saturates the magnitude
      sat_q   <= (absd[15:0] >= {step_q, 1'b0});
    end
    if (cmd_i.div_en) begin
      if (qbit) begin
        rem_q <= rem_q - cand;
      end
      unique case (cmd_i.div_sh)
        2'd2:    code_q[2] <= qbit;
        2'd1:    code_q[1] <= qbit;
        default: code_q[2:0] <= sat_q ? 3'd7 : {code_q[2:1], qbit};
      endcase
    end
    if (cmd_i.mul) begin
      dprod_q <= {15'd0, mag, 1'b1} * {4'd0, step_q};
      sprod_q <= {8'd0, step_q} * {15'd0, step_scale(mag)};
    end
    if (cmd_i.upd) begin
      pcm_q   <= pred_d;
      ocode_q <= code_q;
      ostep_q <= step_d;
    end
  end

  assign status_o.mode     = mode_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign pcm_o       = pcm_q;
  assign code_o      = ocode_q;
  assign step_o      = ostep_q;

endmodule

// ----- src/adpcm_b_codec_step.sv -----
`timescale 1ns / 1ps
// Channel   Direction  tdata                              tuser
// s_axis    in         [7:0] value                        restart
// m_axis    out        [15:0] pcm, [19:16] code,          -
//                      [34:20] step, [39:35] zero
// cfg       in         cfg_wdata_i: mode (0 decode, 1 encode), no read-back
//
// Items are taken one at a time. The encode magnitude comes from a
// restoring divider giving one quotient bit per cycle, then the two step
// products are formed and the predictor and step are updated; decode skips the divider.
// Reset: predictor 0, step 127, mode decode, output register empty.
// A finished result sits in the output register while the next item is
// taken; the update stalls only if that register is still full.

module adpcm_b_codec_step import adpcmb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] value
  input  logic        s_axis_tuser,   // restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [15:0] pcm, [19:16] code, [34:20] step
);

  cmd_t             cmd;
  status_t          status;
  logic [PcmW-1:0]  pcm;
  logic [CodeW-1:0] code;
  logic [StepW-1:0] step;

  adpcmb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  adpcmb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .restart_i   (s_axis_tuser),
    .value_i     (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .pcm_o       (pcm),
    .code_o      (code),
    .step_o      (step)
  );

  assign m_axis_tdata = {5'b00000, step, code, pcm};

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import adpcmb_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 300;
  localparam int SettleCycles = 10;
  localparam logic ModeDecode = 1'b0;
  localparam logic ModeEncode = 1'b1;
  localparam int StepGain [8] = '{57, 57, 57, 57, 77, 102, 128, 153};

  typedef struct {
    logic signed [PcmW-1:0] pcm;
    logic [CodeW-1:0]       code;
    logic [StepW-1:0]       step;
  } codec_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] value
  logic        s_axis_tuser;   // restart
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // [15:0] pcm, [19:16] code, [34:20] step

  // shadow of the codec state, advanced on every input transfer
  int   model_pred;
  int   model_step;
  logic model_mode;

  codec_result_t pending_pcm_q[$];
  codec_result_t due_r;

  int fail_cnt;
  int cycle_cnt;
  int gap_max;
  int burst_left;

  // receiver stall pattern and long hold-off
  int          hold_reqs;
  int          hold_seen;
  int          hold_left;
  logic [31:0] rx_pat;
  int          rx_cnt;
  logic [4:0]  rx_phase;

  adpcm_b_codec_step dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("%0t: timeout, %0d results still pending", $time, pending_pcm_q.size());
      $display("** adpcm_b_codec_step: FAILED **");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_cnt == 0) begin
        rx_pat = $urandom;
        rx_cnt = $urandom_range(16, 200);
        if ($urandom_range(0, 3) == 0) rx_pat = '1;
      end
      rx_cnt--;
      m_axis_tready <= rx_pat[rx_phase];
      rx_phase++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_pcm_q.size() == 0) begin
        $display("%0t: result transfer with nothing pending: tdata %h", $time, m_axis_tdata);
        fail_cnt++;
      end else begin
        due_r = pending_pcm_q.pop_front();
        if (m_axis_tdata[15:0] !== due_r.pcm) begin
          $display("%0t: pcm mismatch: expected %0d, actual %0d", $time, due_r.pcm,
                   $signed(m_axis_tdata[15:0]));
          fail_cnt++;
        end
        if (m_axis_tdata[19:16] !== due_r.code) begin
          $display("%0t: code mismatch: expected %h, actual %h", $time, due_r.code,
                   m_axis_tdata[19:16]);
          fail_cnt++;
        end
        if (m_axis_tdata[34:20] !== due_r.step) begin
          $display("%0t: step mismatch: expected %0d, actual %0d", $time, due_r.step,
                   m_axis_tdata[34:20]);
          fail_cnt++;
        end
      end
    end
  end

  // Offers one item, waits for its transfer and records the result it must give.
  task automatic send_item(input logic restart, input logic [7:0] value);
    int gap;
    int sample;
    int diff;
    int absd;
    int mag;
    int delta;
    int sum;
    int next_step;
    logic [CodeW-1:0] code;
    codec_result_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= restart;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);

    if (restart) begin
      model_pred = 0;
      model_step = int'(StepMin);
    end
    if (model_mode == ModeEncode) begin
      sample = $signed(value);
      diff = sample * 256 - model_pred;
      code[3] = (diff < 0);
      absd = (diff < 0) ? -diff : diff;
      absd = absd * 4 / model_step;
      code[2:0] = (absd > 7) ? 3'd7 : absd[2:0];
    end else begin
      code = value[3:0];
    end
    mag = int'(code[2:0]);
    delta = (2 * mag + 1) * model_step / 8;
    sum = code[3] ? model_pred - delta : model_pred + delta;
    if (sum > 32767) sum = 32767;
    if (sum < -32768) sum = -32768;
    model_pred = sum;
    next_step = model_step * StepGain[mag] / 64;
    if (next_step > int'(StepMax)) next_step = int'(StepMax);
    if (next_step < int'(StepMin)) next_step = int'(StepMin);
    model_step = next_step;

    res.pcm  = model_pred[15:0];
    res.code = code;
    res.step = model_step[14:0];
    pending_pcm_q.push_back(res);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_pcm_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // only called with the codec idle
  task automatic write_mode(input logic m);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    model_mode = m;
  endtask

  task automatic test_decode_directed();
    write_mode(ModeDecode);
    gap_max = 2;
    send_item(1'b1, 8'h00);                     // step falls below minimum, clamped
    repeat (7) send_item(1'b0, 8'hF7);          // upper bits ignored; climb to both maxima
    repeat (3) send_item(1'b0, 8'h0F);          // down to negative saturation
    send_item(1'b0, 8'hA8);                     // sign set, magnitude zero
    wait_idle();
  endtask

  task automatic test_encode_directed();
    write_mode(ModeEncode);                     // state carries over from decode
    gap_max = 2;
    send_item(1'b0, 8'h7F);
    send_item(1'b0, 8'h80);
    send_item(1'b0, 8'h80);
    send_item(1'b1, 8'h00);                     // zero difference after restart
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'h01);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h7F);
    wait_idle();
  endtask

  task automatic test_random_stream();
    int seg;
    int n;
    int walk;
    logic restart;
    logic [7:0] value;
    for (seg = 0; seg < 8; seg++) begin
      write_mode(seg[0] ? ModeEncode : ModeDecode);
      case ($urandom_range(0, 2))
        0:       gap_max = 0;
        1:       gap_max = 3;
        default: gap_max = 8;
      endcase
      walk = 0;
      for (n = 0; n < 110; n++) begin
        restart = ($urandom_range(0, 39) == 0);
        // encode mostly follows a wandering waveform so the step settles
        if (seg[0] && $urandom_range(0, 4) != 0) begin
          if ($urandom_range(0, 1) != 0) walk += $urandom_range(0, 12);
          else walk -= $urandom_range(0, 12);
          if (walk > 127) walk = 127;
          if (walk < -128) walk = -128;
          value = walk[7:0];
        end else begin
          value = 8'($urandom);
          walk = $signed(value);
        end
        send_item(restart, value);
      end
      wait_idle();
    end
  endtask

  // receiver holds off while items keep coming, so the input must stall
  task automatic test_output_backpressure();
    int n;
    write_mode(ModeEncode);
    gap_max = 0;
    hold_reqs++;
    for (n = 0; n < 60; n++) send_item($urandom_range(0, 15) == 0, 8'($urandom));
    wait_idle();
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    fail_cnt = 0;
    cycle_cnt = 0;
    gap_max = 0;
    burst_left = 0;
    hold_reqs = 0;
    hold_seen = 0;
    hold_left = 0;
    rx_cnt = 0;
    rx_phase = '0;
    rx_pat = '1;
    model_pred = 0;
    model_step = int'(StepMin);
    model_mode = ModeDecode;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_decode_directed();
    test_encode_directed();
    test_random_stream();
    test_output_backpressure();

    if (fail_cnt == 0) begin
      $display("** adpcm_b_codec_step: PASSED **");
    end else begin
      $display("** adpcm_b_codec_step: FAILED **");
    end
    $finish;
  end

endmodule
